FILE: rtl/mstk_pkg.sv
// shared types, commands and constants for the kruskal spanning tree core
package mstk_pkg;

  localparam int NODE_W = 4;
  localparam int WGT_W  = 16;
  localparam int CFG_W  = 5;
  localparam int ENTRY_W = WGT_W + 2 * NODE_W;

  typedef struct packed {
    logic signed [WGT_W-1:0]  edge_weight;
    logic        [NODE_W-1:0] end_a;
    logic        [NODE_W-1:0] end_b;
    logic                     final_edge;
  } in_item_t;

  typedef struct packed {
    logic        [NODE_W-1:0] tree_a;
    logic        [NODE_W-1:0] tree_b;
    logic signed [WGT_W-1:0]  tree_weight;
    logic                     edge_valid;
    logic                     run_end;
    logic                     spanning_complete;
    logic                     edges_dropped;
  } out_item_t;

  typedef struct packed {
    logic signed [WGT_W-1:0]  weight;
    logic        [NODE_W-1:0] a;
    logic        [NODE_W-1:0] b;
  } entry_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_PASS,
    S_SCAN,
    S_LA,
    S_LB,
    S_UNION,
    S_EMIT,
    S_P1END,
    S_P2CHK,
    S_EMPTY,
    S_CLEAR
  } state_t;

  typedef struct packed {
    logic load_en;
    logic init_phase;
    logic pass_start;
    logic rd_la;
    logic rd_lb;
    logic merge;
    logic emit;
    logic emit_empty;
    logic finish_p1;
    logic clear_graph;
  } cmd_t;

  typedef struct packed {
    logic final_in;
    logic pass_done;
    logic best_vld;
    logic differ;
    logic at_target;
    logic run_end;
    logic total_zero;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/mstk_ram.sv
// generic single write port ram with registered read
module mstk_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mstk_ctrl.sv
// controller state machine for loading, two scan phases and result output
module mstk_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  mstk_pkg::stat_t stat,
  output mstk_pkg::cmd_t  cmd
);

  mstk_pkg::state_t state_r, state_nxt;
  logic             phase2_r, phase2_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= mstk_pkg::S_LOAD;
      phase2_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase2_r <= phase2_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    phase2_nxt = phase2_r;
    cmd        = '0;
    case (state_r)
      mstk_pkg::S_LOAD: begin
        cmd.load_en = 1'b1;
        phase2_nxt  = 1'b0;
        if (stat.final_in) begin
          state_nxt = mstk_pkg::S_START;
        end
      end
      mstk_pkg::S_START: begin
        cmd.init_phase = 1'b1;
        state_nxt      = mstk_pkg::S_PASS;
      end
      mstk_pkg::S_PASS: begin
        cmd.pass_start = 1'b1;
        state_nxt      = mstk_pkg::S_SCAN;
      end
      mstk_pkg::S_SCAN: begin
        if (stat.pass_done) begin
          if (stat.best_vld) begin
            state_nxt = mstk_pkg::S_LA;
          end else if (phase2_r) begin
            state_nxt = mstk_pkg::S_CLEAR;
          end else begin
            state_nxt = mstk_pkg::S_P1END;
          end
        end
      end
      mstk_pkg::S_LA: begin
        cmd.rd_la = 1'b1;
        state_nxt = mstk_pkg::S_LB;
      end
      mstk_pkg::S_LB: begin
        cmd.rd_lb = 1'b1;
        state_nxt = mstk_pkg::S_UNION;
      end
      mstk_pkg::S_UNION: begin
        if (stat.differ) begin
          cmd.merge = 1'b1;
          if (phase2_r) begin
            state_nxt = mstk_pkg::S_EMIT;
          end else if (stat.at_target) begin
            state_nxt = mstk_pkg::S_P1END;
          end else begin
            state_nxt = mstk_pkg::S_PASS;
          end
        end else begin
          state_nxt = mstk_pkg::S_PASS;
        end
      end
      mstk_pkg::S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.run_end) begin
            state_nxt = mstk_pkg::S_CLEAR;
          end else begin
            state_nxt = mstk_pkg::S_PASS;
          end
        end
      end
      mstk_pkg::S_P1END: begin
        cmd.finish_p1  = 1'b1;
        cmd.init_phase = 1'b1;
        phase2_nxt     = 1'b1;
        state_nxt      = mstk_pkg::S_P2CHK;
      end
      mstk_pkg::S_P2CHK: begin
        if (stat.total_zero) begin
          state_nxt = mstk_pkg::S_EMPTY;
        end else begin
          state_nxt = mstk_pkg::S_PASS;
        end
      end
      mstk_pkg::S_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = mstk_pkg::S_CLEAR;
        end
      end
      mstk_pkg::S_CLEAR: begin
        cmd.clear_graph = 1'b1;
        state_nxt       = mstk_pkg::S_LOAD;
      end
      default: begin
        state_nxt = mstk_pkg::S_LOAD;
      end
    endcase
  end

endmodule

FILE: rtl/mstk_dp.sv
// datapath: edge store, selection scan, component labels and result register
module mstk_dp #(
  parameter int NODES = 16,
  parameter int EDGES = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mstk_pkg::cmd_t                cmd,
  output mstk_pkg::stat_t               stat,
  input  logic                          in_valid,
  input  mstk_pkg::in_item_t            in_data,
  input  logic                          cfg_valid,
  input  logic [mstk_pkg::CFG_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mstk_pkg::out_item_t           out_data
);

  localparam int AW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int CW = $clog2(EDGES + 1);
  localparam int LW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int NW = $clog2(NODES + 1) + 1;

  // configuration and loading
  logic [mstk_pkg::CFG_W-1:0] nodes_r;
  logic [NW-1:0]              nn_eff, nn_r, target;
  logic [CW-1:0]              count_r;
  logic                       drop_r;
  logic                       accept, drop_now, wr_en;

  // scan state
  logic [CW-1:0]         j_r;
  logic                  scan_r, rv_r;
  logic [AW-1:0]         ri_r;
  logic [mstk_pkg::ENTRY_W-1:0] rdata;
  mstk_pkg::entry_t      rd_e, wr_e;
  mstk_pkg::entry_t      best_r, prev_r;
  logic [AW-1:0]         best_i_r, prev_i_r;
  logic                  best_vld_r, have_prev_r;
  logic                  cand, better;

  // labels and counts
  logic [LW-1:0] label_r [NODES];
  logic [LW-1:0] la_r, lb_r, lo, hi;
  logic [NW-1:0] chosen_r, total_r;
  logic          complete_r;

  // output register
  mstk_pkg::out_item_t out_r;
  logic                out_valid_r;

  // effective node count, clamped to 2..NODES
  always_comb begin
    if (nodes_r < mstk_pkg::CFG_W'(2)) begin
      nn_eff = NW'(2);
    end else if ((NW + mstk_pkg::CFG_W)'(nodes_r) > (NW + mstk_pkg::CFG_W)'(NODES)) begin
      nn_eff = NW'(NODES);
    end else begin
      nn_eff = NW'(nodes_r);
    end
  end

  assign target   = nn_r - NW'(1);
  assign accept   = in_valid && cmd.load_en;
  assign drop_now = (NW'(in_data.end_a) >= nn_eff) || (NW'(in_data.end_b) >= nn_eff)
                    || (count_r == CW'(EDGES));
  assign wr_en    = accept && !drop_now;
  assign wr_e     = '{weight: in_data.edge_weight, a: in_data.end_a, b: in_data.end_b};

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nodes_r <= mstk_pkg::CFG_W'(16);
    end else if (cfg_valid) begin
      nodes_r <= cfg_data;
    end
  end

  // edge count, drop flag and node count of the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      drop_r  <= 1'b0;
      nn_r    <= NW'(NODES);
    end else if (cmd.clear_graph) begin
      count_r <= '0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      nn_r <= nn_eff;
      if (drop_now) begin
        drop_r <= 1'b1;
      end else begin
        count_r <= count_r + CW'(1);
      end
    end
  end

  mstk_ram #(
    .WIDTH (mstk_pkg::ENTRY_W),
    .DEPTH (EDGES)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_r[AW-1:0]),
    .wdata (wr_e),
    .raddr (j_r[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_e = mstk_pkg::entry_t'(rdata);

  // an entry is a candidate if it comes after the last pick in (weight, index) order
  assign cand   = !have_prev_r || (rd_e.weight > prev_r.weight)
                  || ((rd_e.weight == prev_r.weight) && (ri_r > prev_i_r));
  assign better = !best_vld_r || (rd_e.weight < best_r.weight);

  // selection pass: one entry read per cycle, smallest candidate kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= 1'b0;
      rv_r        <= 1'b0;
      j_r         <= '0;
      best_vld_r  <= 1'b0;
      have_prev_r <= 1'b0;
    end else begin
      rv_r <= scan_r && (j_r < count_r);
      ri_r <= j_r[AW-1:0];
      if (cmd.init_phase) begin
        best_vld_r  <= 1'b0;
        have_prev_r <= 1'b0;
      end else if (cmd.pass_start) begin
        if (best_vld_r) begin
          prev_r      <= best_r;
          prev_i_r    <= best_i_r;
          have_prev_r <= 1'b1;
        end
        best_vld_r <= 1'b0;
        j_r        <= '0;
        scan_r     <= 1'b1;
      end else begin
        if (scan_r) begin
          if (j_r < count_r) begin
            j_r <= j_r + CW'(1);
          end else if (!rv_r) begin
            scan_r <= 1'b0;
          end
        end
        if (rv_r && cand && better) begin
          best_r     <= rd_e;
          best_i_r   <= ri_r;
          best_vld_r <= 1'b1;
        end
      end
    end
  end

  assign lo = (la_r < lb_r) ? la_r : lb_r;
  assign hi = (la_r < lb_r) ? lb_r : la_r;

  // component labels: endpoint lookups and relabel of the component with the larger label
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NODES; k++) begin
        label_r[k] <= LW'(k);
      end
    end else if (cmd.init_phase) begin
      for (int k = 0; k < NODES; k++) begin
        label_r[k] <= LW'(k);
      end
    end else if (cmd.merge) begin
      for (int k = 0; k < NODES; k++) begin
        if (label_r[k] == hi) begin
          label_r[k] <= lo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_la) begin
      la_r <= label_r[LW'(best_r.a)];
    end
    if (cmd.rd_lb) begin
      lb_r <= label_r[LW'(best_r.b)];
    end
  end

  // chosen count, phase one total and completion flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chosen_r   <= '0;
      total_r    <= '0;
      complete_r <= 1'b0;
    end else begin
      if (cmd.finish_p1) begin
        total_r    <= chosen_r;
        complete_r <= (chosen_r == target);
      end
      if (cmd.init_phase || cmd.clear_graph) begin
        chosen_r <= '0;
      end else if (cmd.merge) begin
        chosen_r <= chosen_r + NW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.emit_empty) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.tree_a            <= best_r.a;
      out_r.tree_b            <= best_r.b;
      out_r.tree_weight       <= best_r.weight;
      out_r.edge_valid        <= 1'b1;
      out_r.run_end           <= (chosen_r == total_r);
      out_r.spanning_complete <= complete_r;
      out_r.edges_dropped     <= drop_r;
    end else if (cmd.emit_empty) begin
      out_r.tree_a            <= '0;
      out_r.tree_b            <= '0;
      out_r.tree_weight       <= '0;
      out_r.edge_valid        <= 1'b0;
      out_r.run_end           <= 1'b1;
      out_r.spanning_complete <= complete_r;
      out_r.edges_dropped     <= drop_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // status to the controller
  assign stat.final_in   = accept && in_data.final_edge;
  assign stat.pass_done  = scan_r && (j_r == count_r) && !rv_r;
  assign stat.best_vld   = best_vld_r;
  assign stat.differ     = (la_r != lb_r);
  assign stat.at_target  = (NW'(chosen_r + NW'(1)) == target);
  assign stat.run_end    = (chosen_r == total_r);
  assign stat.total_zero = (total_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;

endmodule

FILE: rtl/minimum_spanning_tree_kruskal_core.sv
// top level of the kruskal minimum spanning tree core
// Use: write nodes_in_use on the cfg channel while the core is idle (reset value 16).
// Edges arrive on the in channel, one item per cycle while loading; the item with
// final_edge set closes the graph and starts the run. Edges with an endpoint not
// below the node count, or beyond EDGES stored, are dropped and flagged.
// The run makes two phases over the edge store. Each phase picks edges in
// ascending (weight, arrival) order, one pick per pass; a pass reads the whole
// store through the single read port of the edge memory.
// A phase takes one pass for each edge it examines plus a closing pass when the
// edges run out; phase one counts the tree edges, phase two emits them; the first
// result follows phase one and the phase two passes up to the first tree edge.
// Results leave on the out channel, one item per chosen edge, or one empty item
// when none is chosen; run_end marks the last. A stalled receiver holds the core
// in its emit step, no work is lost. After the run the graph state clears and the
// in channel is ready again, even while the last result waits in its register.
// Reset is synchronous: state, node count and labels return to their reset values.
module minimum_spanning_tree_kruskal_core #(
  parameter int NODES = 16,
  parameter int EDGES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  mstk_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output mstk_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [mstk_pkg::CFG_W-1:0] cfg_data
);

  mstk_pkg::cmd_t  cmd;
  mstk_pkg::stat_t stat;

  // controller
  mstk_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath
  mstk_dp #(
    .NODES (NODES),
    .EDGES (EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready  = cmd.load_en;
  assign cfg_ready = 1'b1;

endmodule

FILE: rtl/mstk_checker.sv
// port level checks for the kruskal core and their bind
module mstk_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input mstk_pkg::in_item_t         in_data,
  input logic                       out_valid,
  input logic                       out_ready,
  input mstk_pkg::out_item_t        out_data,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [mstk_pkg::CFG_W-1:0] cfg_data
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item changed while stalled");

  // reset empties the result register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty result always closes the run
  a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.edge_valid |-> out_data.run_end)
    else $error("empty result without run end");

  // no edge is taken while a result that does not end the run is shown
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_end |-> !in_ready)
    else $error("input ready in the middle of a run");

endmodule

bind minimum_spanning_tree_kruskal_core mstk_checker u_mstk_checker (.*);
